// ===== rtl/edf_pkg.sv =====
// ----------------------------------------------------------------------------
// EDF queue engine package
// Shared types and constants for the ready/wait queue engine.
// ----------------------------------------------------------------------------
`default_nettype none

package edf_pkg;

  localparam int unsigned PoolDepth = 16;
  localparam int unsigned IdxW      = $clog2(PoolDepth);
  localparam int unsigned CntW      = $clog2(PoolDepth + 1);

  typedef enum logic [2:0] {
    REQ_ADD_READY = 3'd0,
    REQ_ADD_WAIT  = 3'd1,
    REQ_NEXT      = 3'd2,
    REQ_TRANSFER  = 3'd3,
    REQ_PEEK_WAIT = 3'd4
  } req_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_WRITE,
    S_POP_RD,
    S_POP_WR,
    S_HEAD_RD,
    S_HEAD_CHK,
    S_RESULT
  } state_e;

  // a ready or wait entry: id in the low byte, deadline above
  typedef struct packed {
    logic [31:0] deadline;
    logic [7:0]  id;
  } entry_t;

endpackage

`default_nettype wire

// ===== rtl/edf_ram.sv =====
// ----------------------------------------------------------------------------
// EDF generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module edf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/edf_ready_wait_queue_engine.sv =====
// ----------------------------------------------------------------------------
// EDF ready/wait queue engine
// Deadline-sorted ready list, no-deadline FIFO and periodic wait list.
// ----------------------------------------------------------------------------
// One request at a time; s_axis_tready is low from accept until the result
//   transfer, so the next request is taken in the cycle after that transfer at best.
// Reset (rst_ni low, async) empties all queues; RAM contents stay unknown.
`default_nettype none

module edf_ready_wait_queue_engine
  import edf_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output      logic         s_axis_tready,
  // req_type[2:0], task_id[10:3], task_deadline[42:11], task_period[74:43],
  // no_deadline_flag[75], periodic_flag[76], now_ticks[108:77], zero fill
  input  wire logic [111:0] s_axis_tdata,
  output      logic         m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // status[1:0], out_task_id[9:2], out_deadline[41:10], moved_count[46:42], fill
  output      logic [47:0]  m_axis_tdata
);

  state_e state_q, state_d;

  // request registers
  logic [2:0]  req_q;
  logic [7:0]  id_q;
  logic [31:0] dl_q, per_q, now_q;
  logic        nodl_q, per_f_q;

  logic [CntW-1:0] rcnt_q, rcnt_d, wcnt_q, wcnt_d, fcnt_q, fcnt_d;
  logic [IdxW-1:0] fhead_q, fhead_d;

  // walk control
  logic            tgt_wait_q, tgt_wait_d;    // list being edited
  logic [CntW-1:0] pos_q, pos_d;              // scan / shift index
  logic [CntW-1:0] ins_q, ins_d;              // insert position
  logic            xfer_q, xfer_d;            // insert is part of transfer
  entry_t          ne_q, ne_d;                // entry being inserted
  logic [31:0]     np_q, np_d;                // period being inserted
  logic [4:0]      moved_q, moved_d;

  logic [1:0]  st_q, st_d;
  logic [7:0]  oid_q, oid_d;
  logic [31:0] odl_q, odl_d;
  logic        ovld_q, ovld_d;

  // RAM ports
  logic            r_we, w_we, p_we, f_we;
  logic [IdxW-1:0] r_wa, w_wa, p_wa, f_wa, r_ra, w_ra, p_ra, f_ra;
  entry_t          r_wd, w_wd, r_rd, w_rd;
  logic [31:0]     p_wd, p_rd;
  logic [7:0]      f_rd;

  edf_ram #(.Width(40), .Depth(PoolDepth)) u_ready (
    .clk_i, .we_i(r_we), .waddr_i(r_wa), .wdata_i(r_wd), .raddr_i(r_ra), .rdata_o(r_rd));
  edf_ram #(.Width(40), .Depth(PoolDepth)) u_wait (
    .clk_i, .we_i(w_we), .waddr_i(w_wa), .wdata_i(w_wd), .raddr_i(w_ra), .rdata_o(w_rd));
  edf_ram #(.Width(32), .Depth(PoolDepth)) u_per (
    .clk_i, .we_i(p_we), .waddr_i(p_wa), .wdata_i(p_wd), .raddr_i(p_ra), .rdata_o(p_rd));
  edf_ram #(.Width(8), .Depth(PoolDepth)) u_fifo (
    .clk_i, .we_i(f_we), .waddr_i(f_wa), .wdata_i(id_q), .raddr_i(f_ra), .rdata_o(f_rd));

  logic            in_acc;
  logic            full;
  logic [CntW+1:0] used;
  logic [CntW-1:0] lcnt;
  entry_t          rd_e;
  logic [31:0]     add_a, add_b;
  logic [31:0]     sum;     // the shared adder

  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE) && !ovld_q;
  assign used = {2'b0, rcnt_q} + {2'b0, wcnt_q} + {2'b0, fcnt_q};
  assign full = used >= (CntW + 2)'(PoolDepth);
  assign lcnt = tgt_wait_q ? wcnt_q : rcnt_q;
  assign rd_e = tgt_wait_q ? w_rd : r_rd;

  // wait head advance while popping, request deadline advance otherwise
  assign add_a = (state_q == S_POP_RD) ? w_rd.deadline : dl_q;
  assign add_b = (state_q == S_POP_RD) ? p_rd : per_q;
  assign sum   = add_a + add_b;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rcnt_q  <= '0;
      wcnt_q  <= '0;
      fcnt_q  <= '0;
      fhead_q <= '0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      rcnt_q  <= rcnt_d;
      wcnt_q  <= wcnt_d;
      fcnt_q  <= fcnt_d;
      fhead_q <= fhead_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q   <= s_axis_tdata[2:0];
      id_q    <= s_axis_tdata[10:3];
      dl_q    <= s_axis_tdata[42:11];
      per_q   <= s_axis_tdata[74:43];
      nodl_q  <= s_axis_tdata[75];
      per_f_q <= s_axis_tdata[76];
      now_q   <= s_axis_tdata[108:77];
    end
    tgt_wait_q <= tgt_wait_d;
    pos_q      <= pos_d;
    ins_q      <= ins_d;
    xfer_q     <= xfer_d;
    ne_q       <= ne_d;
    np_q       <= np_d;
    moved_q    <= moved_d;
    st_q       <= st_d;
    oid_q      <= oid_d;
    odl_q      <= odl_d;
  end

  always_comb begin
    state_d    = state_q;
    rcnt_d     = rcnt_q;
    wcnt_d     = wcnt_q;
    fcnt_d     = fcnt_q;
    fhead_d    = fhead_q;
    ovld_d     = ovld_q;
    tgt_wait_d = tgt_wait_q;
    pos_d      = pos_q;
    ins_d      = ins_q;
    xfer_d     = xfer_q;
    ne_d       = ne_q;
    np_d       = np_q;
    moved_d    = moved_q;
    st_d       = st_q;
    oid_d      = oid_q;
    odl_d      = odl_q;
    r_we = 1'b0; w_we = 1'b0; p_we = 1'b0; f_we = 1'b0;
    r_wa = pos_q[IdxW-1:0];
    w_wa = pos_q[IdxW-1:0];
    p_wa = pos_q[IdxW-1:0];
    f_wa = IdxW'(({1'b0, fhead_q} + fcnt_q[IdxW:0]) & (IdxW+1)'(PoolDepth - 1));
    r_ra = pos_q[IdxW-1:0];
    w_ra = pos_q[IdxW-1:0];
    p_ra = pos_q[IdxW-1:0];
    f_ra = fhead_q;
    r_wd = rd_e;
    w_wd = rd_e;
    p_wd = p_rd;

    if (m_axis_tvalid && m_axis_tready) ovld_d = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_RESULT;
          st_d = ST_OK; oid_d = '0; odl_d = '0; moved_d = '0;
          xfer_d = 1'b0; pos_d = '0; ins_d = '0;
          unique case (s_axis_tdata[2:0]) inside
            REQ_ADD_READY, REQ_ADD_WAIT, REQ_NEXT, REQ_TRANSFER, REQ_PEEK_WAIT:
              state_d = S_HEAD_RD;   // decode after registering
            default: state_d = S_RESULT;
          endcase
        end
      end
      S_HEAD_RD: begin
        // request is registered; dispatch
        state_d = S_RESULT;
        unique case (req_q)
          REQ_ADD_READY: begin
            oid_d = id_q;
            if (nodl_q && !per_f_q) begin
              if (full) st_d = ST_FULL;
              else begin
                f_we = 1'b1;
                fcnt_d = fcnt_q + 1'b1;
              end
            end else begin
              ne_d.id = id_q;
              ne_d.deadline = (dl_q <= now_q) ? sum : dl_q;
              odl_d = ne_d.deadline;
              tgt_wait_d = 1'b0;
              if (full) st_d = ST_FULL;
              else state_d = S_SCAN_RD;
            end
          end
          REQ_ADD_WAIT: begin
            if (per_f_q) begin
              oid_d = id_q; odl_d = dl_q;
              ne_d.id = id_q; ne_d.deadline = dl_q; np_d = per_q;
              tgt_wait_d = 1'b1;
              if (full) st_d = ST_FULL;
              else state_d = S_SCAN_RD;
            end
          end
          REQ_NEXT: begin
            if (rcnt_q != '0) begin
              tgt_wait_d = 1'b0; state_d = S_POP_RD;
            end else if (fcnt_q != '0) begin
              state_d = S_POP_RD; tgt_wait_d = 1'b0;
            end else st_d = ST_EMPTY;
          end
          REQ_TRANSFER: begin
            tgt_wait_d = 1'b1; state_d = S_HEAD_CHK;
          end
          REQ_PEEK_WAIT: begin
            if (wcnt_q != '0) begin
              tgt_wait_d = 1'b1; state_d = S_HEAD_CHK;
            end else st_d = ST_EMPTY;
          end
          default: ;
        endcase
      end
      S_HEAD_CHK: begin
        // wait head read issued here at pos 0 (pos_q is 0 here)
        w_ra = '0; p_ra = '0;
        state_d = S_POP_RD;
        if (req_q == REQ_TRANSFER && wcnt_q == '0) state_d = S_RESULT;
      end
      S_POP_RD: begin
        // head data of the addressed RAM is valid now (read at index 0, or at the FIFO head)
        if (req_q == REQ_NEXT && rcnt_q == '0) begin
          oid_d = f_rd;
          fhead_d = fhead_q + 1'b1;
          fcnt_d = fcnt_q - 1'b1;
          state_d = S_RESULT;
        end else if (req_q == REQ_PEEK_WAIT) begin
          oid_d = w_rd.id; odl_d = w_rd.deadline;
          state_d = S_RESULT;
        end else if (req_q == REQ_TRANSFER) begin
          if (now_q >= w_rd.deadline) begin
            ne_d.id = w_rd.id;
            ne_d.deadline = sum;
            xfer_d = 1'b1;
            pos_d = CntW'(1);
            state_d = S_POP_WR;
          end else state_d = S_RESULT;
        end else begin
          oid_d = r_rd.id; odl_d = r_rd.deadline;
          pos_d = CntW'(1);
          state_d = S_POP_WR;
        end
      end
      S_POP_WR: begin
        // shift list down: read pos, write pos-1 next cycle
        if (pos_q >= lcnt) begin
          if (tgt_wait_q) wcnt_d = wcnt_q - 1'b1;
          else rcnt_d = rcnt_q - 1'b1;
          if (xfer_q) begin
            tgt_wait_d = 1'b0; pos_d = '0; state_d = S_SCAN_RD;
          end else state_d = S_RESULT;
        end else state_d = S_SHIFT_RD;
      end
      S_SHIFT_RD: begin
        // data at pos_q is out of the RAM now
        w_wa = IdxW'(pos_q - 1'b1); r_wa = w_wa; p_wa = w_wa;
        if (tgt_wait_q) begin w_we = 1'b1; p_we = 1'b1; end
        else r_we = 1'b1;
        pos_d = pos_q + 1'b1;
        state_d = S_POP_WR;
      end
      S_SCAN_RD: begin
        if (pos_q >= lcnt) begin
          ins_d = pos_q; pos_d = lcnt; state_d = S_SHIFT_WR;
        end else state_d = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if (rd_e.deadline <= ne_q.deadline) begin
          pos_d = pos_q + 1'b1; state_d = S_SCAN_RD;
        end else begin
          ins_d = pos_q; pos_d = lcnt; state_d = S_SHIFT_WR;
        end
      end
      S_SHIFT_WR: begin
        // move entries up from the tail: read pos-1 now, write pos in S_WRITE
        if (pos_q == ins_q) state_d = S_WRITE;
        else begin
          r_ra = IdxW'(pos_q - 1'b1); w_ra = r_ra; p_ra = r_ra;
          state_d = S_WRITE;
        end
      end
      S_WRITE: begin
        if (pos_q == ins_q) begin
          r_wd = ne_q; w_wd = ne_q; p_wd = np_q;
          if (tgt_wait_q) begin
            w_we = 1'b1; p_we = 1'b1; wcnt_d = wcnt_q + 1'b1;
          end else begin
            r_we = 1'b1; rcnt_d = rcnt_q + 1'b1;
          end
          if (xfer_q) begin
            if (moved_q != 5'd31) moved_d = moved_q + 1'b1;
            tgt_wait_d = 1'b1; pos_d = '0; xfer_d = 1'b0;
            state_d = S_HEAD_CHK;
          end else state_d = S_RESULT;
        end else begin
          if (tgt_wait_q) begin w_we = 1'b1; p_we = 1'b1; end
          else r_we = 1'b1;
          pos_d = pos_q - 1'b1;
          state_d = S_SHIFT_WR;
        end
      end
      S_RESULT: begin
        ovld_d = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = {1'b0, moved_q, odl_q, oid_q, st_q};

  // A result never appears while a request is still in work.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> state_q == S_IDLE)
    else $error("result while busy");
  // The pool never holds more than its depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    used <= (CntW + 2)'(PoolDepth))
    else $error("pool overfilled");
  // An accepted request produces a result after work completes.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RESULT |=> m_axis_tvalid)
    else $error("result lost");

endmodule

`default_nettype wire

// ===== tb/sv/edf_queue_checker.sv =====
// ----------------------------------------------------------------------------
// EDF queue engine checker
// Watches both stream channels, predicts each response from its own model of
// the ready list, no-deadline FIFO and wait list, and compares field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module edf_queue_checker
  import edf_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  input  wire logic         s_axis_tready,
  input  wire logic [111:0] s_axis_tdata,
  input  wire logic         m_axis_tvalid,
  input  wire logic         m_axis_tready,
  input  wire logic [47:0]  m_axis_tdata,
  output int                fail_count_o,
  output int                pending_o,
  output logic [4:0]        ready_len_o,
  output logic [4:0]        fifo_len_o,
  output logic [4:0]        wait_len_o
);

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  task_id;
    logic [31:0] deadline;
    logic [4:0]  moved;
  } resp_t;

  entry_t      ready_list[$];
  logic [7:0]  fifo_ids[$];
  entry_t      wait_list[$];
  logic [31:0] wait_per[$];
  resp_t       expected_resp[$];
  int          fail_count;

  function automatic int pool_used();
    return ready_list.size() + fifo_ids.size() + wait_list.size();
  endfunction

  // insert behind every entry with deadline <= new one
  function automatic void ready_push(entry_t e);
    int p;
    p = 0;
    while (p < ready_list.size() && ready_list[p].deadline <= e.deadline) p++;
    ready_list.insert(p, e);
  endfunction

  function automatic resp_t predict_response(logic [111:0] d);
    resp_t r;
    req_e        req;
    logic [7:0]  id;
    logic [31:0] dl, per, now;
    logic        nodl, periodic;
    entry_t      e;
    int          p;
    r = '0;
    req = req_e'(d[2:0]);
    id = d[10:3];
    dl = d[42:11];
    per = d[74:43];
    nodl = d[75];
    periodic = d[76];
    now = d[108:77];
    case (req)
      REQ_ADD_READY: begin
        r.task_id = id;
        if (nodl && !periodic) begin
          if (pool_used() >= PoolDepth) r.status = ST_FULL;
          else fifo_ids.push_back(id);
        end else begin
          if (dl <= now) dl = dl + per;
          r.deadline = dl;
          e.id = id;
          e.deadline = dl;
          if (pool_used() >= PoolDepth) r.status = ST_FULL;
          else ready_push(e);
        end
      end
      REQ_ADD_WAIT: begin
        if (periodic) begin
          r.task_id = id;
          r.deadline = dl;
          if (pool_used() >= PoolDepth) r.status = ST_FULL;
          else begin
            p = 0;
            while (p < wait_list.size() && wait_list[p].deadline <= dl) p++;
            e.id = id;
            e.deadline = dl;
            wait_list.insert(p, e);
            wait_per.insert(p, per);
          end
        end
      end
      REQ_NEXT: begin
        if (ready_list.size() > 0) begin
          e = ready_list.pop_front();
          r.task_id = e.id;
          r.deadline = e.deadline;
        end else if (fifo_ids.size() > 0) begin
          r.task_id = fifo_ids.pop_front();
        end else r.status = ST_EMPTY;
      end
      REQ_TRANSFER: begin
        while (wait_list.size() > 0 && now >= wait_list[0].deadline) begin
          e = wait_list.pop_front();
          e.deadline = e.deadline + wait_per.pop_front();
          ready_push(e);
          if (r.moved != 5'd31) r.moved = r.moved + 1'b1;
        end
      end
      REQ_PEEK_WAIT: begin
        if (wait_list.size() > 0) begin
          r.task_id = wait_list[0].id;
          r.deadline = wait_list[0].deadline;
        end else r.status = ST_EMPTY;
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    resp_t want, got;
    if (!rst_ni) begin
      fail_count  <= 0;
      pending_o   <= 0;
      ready_len_o <= '0;
      fifo_len_o  <= '0;
      wait_len_o  <= '0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.status = m_axis_tdata[1:0];
        got.task_id = m_axis_tdata[9:2];
        got.deadline = m_axis_tdata[41:10];
        got.moved = m_axis_tdata[46:42];
        if (expected_resp.size() == 0) begin
          $error("unexpected response transfer %h", m_axis_tdata);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_resp.pop_front();
          if (want != got) fail_count <= fail_count + 1;
          if (want.status != got.status)
            $error("status: expected %0d actual %0d", want.status, got.status);
          if (want.task_id != got.task_id)
            $error("out_task_id: expected %0d actual %0d", want.task_id, got.task_id);
          if (want.deadline != got.deadline)
            $error("out_deadline: expected %h actual %h", want.deadline, got.deadline);
          if (want.moved != got.moved)
            $error("moved_count: expected %0d actual %0d", want.moved, got.moved);
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_resp.push_back(predict_response(s_axis_tdata));
      pending_o   <= expected_resp.size();
      ready_len_o <= 5'(ready_list.size());
      fifo_len_o  <= 5'(fifo_ids.size());
      wait_len_o  <= 5'(wait_list.size());
    end
  end

  assign fail_count_o = fail_count;

endmodule

`default_nettype wire

// ===== tb/sv/edf_ready_wait_queue_engine_tb.sv =====
// ----------------------------------------------------------------------------
// EDF queue engine testbench
// Directed corner requests, then random request mixes with random idling on
// both channels and a long response stall that backs up the request side.
// ----------------------------------------------------------------------------
`default_nettype none

module edf_ready_wait_queue_engine_tb;
  import edf_pkg::*;

  localparam int WatchdogLimit = 20000;
  localparam int QuietCycles   = 2500;
  localparam int StallCycles   = 600;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [111:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [47:0]  m_axis_tdata;
  int           fail_count, pending;
  logic [4:0]   ready_len, fifo_len, wait_len;
  logic         stim_done = 1'b0;
  logic         quiet_go = 1'b0;
  logic         stall_go = 1'b0;
  logic         quiet_used = 1'b0;
  logic         stall_used = 1'b0;
  int           quiet_left = 0;
  int           stall_left = 0;
  int           idle_cycles_wd = 0;

  always #5 clk_i = ~clk_i;

  edf_ready_wait_queue_engine u_dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  edf_queue_checker u_checker (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .fail_count_o(fail_count), .pending_o(pending),
    .ready_len_o(ready_len), .fifo_len_o(fifo_len), .wait_len_o(wait_len)
  );

  function automatic logic [111:0] pack_req(logic [2:0] req, logic [7:0] id,
      logic [31:0] dl, logic [31:0] per, logic nodl, logic periodic,
      logic [31:0] now);
    return {3'b0, now, periodic, nodl, per, dl, id, req};
  endfunction

  // one transfer, with optional idle cycles ahead of it
  task automatic send(logic [111:0] d, bit may_idle);
    if (may_idle) begin
      while ($urandom_range(99) < 30) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_word(int mode);
    case (mode)
      0: return 32'hFFFF_FFFF - $urandom_range(40);
      1: return $urandom_range(60);
      default: return $urandom();
    endcase
  endfunction

  // random request; weights follow pool occupancy to keep lists busy
  task automatic send_random(bit may_idle);
    logic [2:0]  req;
    int          pick, m;
    logic [31:0] base, now;
    pick = $urandom_range(99);
    m = $urandom_range(2);
    base = rand_word(m);
    now = base + $urandom_range(40) - 20;
    if ($urandom_range(19) == 0) now = $urandom();
    if (pick < 30) req = REQ_ADD_READY;
    else if (pick < 55) req = REQ_ADD_WAIT;
    else if (pick < 75) req = REQ_NEXT;
    else if (pick < 88) req = REQ_TRANSFER;
    else if (pick < 96) req = REQ_PEEK_WAIT;
    else req = 3'($urandom_range(7));
    if (ready_len + fifo_len + wait_len > 13 && pick < 55 && $urandom_range(1))
      req = REQ_NEXT;
    send(pack_req(req, 8'($urandom()), base + $urandom_range(30) - 15,
                  ($urandom_range(3) == 0) ? $urandom() : $urandom_range(25),
                  1'($urandom_range(1)), $urandom_range(3) != 0, now), may_idle);
  endtask

  // receiver: random idling, a quiet stretch, and one long hold-off
  always @(posedge clk_i) begin
    if (stall_go && !stall_used) begin
      stall_used <= 1'b1;
      stall_left <= StallCycles - 1;
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (quiet_go && !quiet_used) begin
      quiet_used <= 1'b1;
      quiet_left <= QuietCycles - 1;
      m_axis_tready <= 1'b1;
    end else if (quiet_left > 0) begin
      quiet_left <= quiet_left - 1;
      m_axis_tready <= 1'b1;
    end else m_axis_tready <= ($urandom_range(99) >= 30);
  end

  initial begin
    int n;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed
    send(pack_req(REQ_NEXT, 0, 0, 0, 0, 0, 0), 0);
    send(pack_req(REQ_PEEK_WAIT, 0, 0, 0, 0, 0, 0), 0);
    send(pack_req(REQ_TRANSFER, 0, 0, 0, 0, 0, 32'hFFFF_FFFF), 0);
    send(pack_req(REQ_ADD_READY, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 1,
                  32'hFFFF_FFFF), 0);
    send(pack_req(REQ_ADD_READY, 8'h00, 0, 5, 0, 0, 0), 0);
    send(pack_req(REQ_ADD_READY, 8'h11, 100, 7, 0, 0, 50), 0);
    send(pack_req(REQ_ADD_READY, 8'h12, 100, 7, 0, 0, 50), 0);
    send(pack_req(REQ_ADD_READY, 8'h33, 9, 9, 1, 0, 0), 0);
    send(pack_req(REQ_ADD_READY, 8'h34, 9, 9, 1, 1, 0), 0);
    send(pack_req(REQ_ADD_WAIT, 8'h40, 20, 3, 0, 0, 0), 0);
    send(pack_req(REQ_ADD_WAIT, 8'h41, 20, 32'hFFFF_FFFF, 1, 1, 0), 0);
    send(pack_req(REQ_ADD_WAIT, 8'h42, 20, 4, 0, 1, 0), 0);
    send(pack_req(REQ_ADD_WAIT, 8'h43, 32'hFFFF_FFFF, 4, 0, 1, 0), 0);
    send(pack_req(REQ_PEEK_WAIT, 0, 0, 0, 0, 0, 0), 0);
    send(pack_req(REQ_TRANSFER, 0, 0, 0, 0, 0, 19), 0);
    send(pack_req(REQ_TRANSFER, 0, 0, 0, 0, 0, 32'hFFFF_FFFF), 0);
    send(pack_req(3'd5, 8'hAA, 1, 1, 1, 1, 1), 0);
    send(pack_req(3'd7, 8'h55, 2, 2, 0, 0, 2), 0);
    for (n = 0; n < 12; n++)
      send(pack_req(REQ_ADD_READY, 8'(n), 32'(n), 0, n[0], 0, 0), 0);
    for (n = 0; n < 18; n++) send(pack_req(REQ_NEXT, 0, 0, 0, 0, 0, 0), 0);
    // random, first stretch without idling
    quiet_go <= 1'b1;
    for (n = 0; n < 150; n++) send_random(0);
    stall_go <= 1'b1;
    for (n = 0; n < 1650; n++) send_random(1);
    s_axis_tvalid <= 1'b0;
    stim_done <= 1'b1;
  end

  // watchdog and verdict
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (stim_done && pending == 0))
      idle_cycles_wd <= 0;
    else idle_cycles_wd <= idle_cycles_wd + 1;
  end

  initial begin
    int k;
    wait (stim_done);
    k = 0;
    while (pending != 0 && k < WatchdogLimit) begin
      @(posedge clk_i);
      k++;
    end
    repeat (200) @(posedge clk_i);
    if (fail_count == 0 && pending == 0 && k < WatchdogLimit)
      $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    wait (idle_cycles_wd >= WatchdogLimit);
    $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire
